@@ rtl/core/lfsa_pkg.sv @@
package lfsa_pkg;

	localparam int SLOT_COUNT = 1024;
	localparam int SLOT_W     = 10;
	localparam int HINT_W     = 11;
	localparam int WORD_W     = 32;
	localparam int BIT_W      = $clog2(WORD_W);
	localparam int WORD_COUNT = SLOT_COUNT / WORD_W;
	localparam int WSEL_W     = $clog2(WORD_COUNT);

	localparam logic [HINT_W-1:0] HINT_FULL  = HINT_W'(SLOT_COUNT);
	localparam logic [HINT_W-1:0] HINT_RESET = HINT_W'(1);
	localparam logic [WSEL_W-1:0] LAST_WORD  = WSEL_W'(WORD_COUNT - 1);

	localparam logic REQ_RESERVE = 1'b0;
	localparam logic REQ_RELEASE = 1'b1;

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_FULL        = 2'd1,
		ST_BAD_RELEASE = 2'd2
	} status_t;

	typedef struct packed {
		logic              req_type;
		logic [SLOT_W-1:0] slot_number;
	} req_item_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [SLOT_W-1:0] granted_slot;
		logic [HINT_W-1:0] next_free_hint;
	} resp_item_t;

	// bitmap port requests: one read and one write per cycle
	typedef struct packed {
		logic              rd_en;
		logic [WSEL_W-1:0] rd_addr;
		logic              wr_en;
		logic [WSEL_W-1:0] wr_addr;
		logic [WORD_W-1:0] wr_data;
	} bmp_req_t;

	typedef struct packed {
		logic             found;
		logic [BIT_W-1:0] idx;
	} zero_pos_t;

	// lowest clear bit of a word
	function automatic zero_pos_t first_zero(input logic [WORD_W-1:0] w);
		zero_pos_t r;
		r = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (!w[i]) begin
				r.found = 1'b1;
				r.idx   = BIT_W'(i);
			end
		end
		return r;
	endfunction

	// bits 0..p set
	function automatic logic [WORD_W-1:0] low_mask(input logic [BIT_W-1:0] p);
		logic [WORD_W-1:0] m;
		for (int i = 0; i < WORD_W; i++) begin
			m[i] = (BIT_W'(i) <= p);
		end
		return m;
	endfunction

	function automatic logic [WORD_W-1:0] bit_sel(input logic [BIT_W-1:0] p);
		logic [WORD_W-1:0] m;
		m = '0;
		m[p] = 1'b1;
		return m;
	endfunction

endpackage

@@ rtl/core/lfsa_bitmap.sv @@
module lfsa_bitmap (
	input  logic                            clk,
	input  logic                            arst_n,
	input  lfsa_pkg::bmp_req_t              req,
	output logic [lfsa_pkg::WORD_W-1:0]     rd_data
);

	logic [lfsa_pkg::WORD_W-1:0]     mem [lfsa_pkg::WORD_COUNT];
	logic [lfsa_pkg::WORD_COUNT-1:0] word_vld_q;
	logic [lfsa_pkg::WORD_W-1:0]     raw_s1;
	logic                            vld_s1;

	// unwritten words read as all free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_vld_q <= '0;
			vld_s1     <= 1'b0;
		end else begin
			if (req.wr_en) begin
				word_vld_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				vld_s1 <= word_vld_q[req.rd_addr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			raw_s1 <= mem[req.rd_addr];
		end
	end

	assign rd_data = vld_s1 ? raw_s1 : '0;

endmodule

@@ rtl/core/lowest_free_slot_allocator.sv @@
// Channel | Handshake                  | Payload
// --------+----------------------------+------------------------------------
// in      | in_valid / in_ready        | in_data  (req_type, slot_number)
// out     | out_valid / out_ready      | out_data (status, granted_slot,
//         |                            |           next_free_hint)
//
// Release, full reserve, bad release: the word is read on accept, checked and
// written in S_MODIFY; the result loads from S_OUT. Reserve adds an S_SCAN step
// per word scanned past the granted word (0..31). The scan reads one 32-slot
// word per cycle; in_ready rises as the result loads. One item in flight; a new
// item is taken while the last result waits at out, then stalls until it drains.
// Reset frees all slots at once through per-word valid bits; hint resets to 1.
module lowest_free_slot_allocator (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  lfsa_pkg::req_item_t    in_data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output lfsa_pkg::resp_item_t   out_data
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_MODIFY,
		S_SCAN,
		S_OUT
	} state_t;

	state_t                          state_q;
	logic [lfsa_pkg::HINT_W-1:0]     hint_q;
	logic                            req_q;
	logic [lfsa_pkg::SLOT_W-1:0]     slot_q;
	logic [lfsa_pkg::WSEL_W-1:0]     word_q;
	lfsa_pkg::resp_item_t            resp_q;

	lfsa_pkg::bmp_req_t              bmp_req;
	logic [lfsa_pkg::WORD_W-1:0]     rd_data;

	// combinational results of the current step
	logic                            done;
	lfsa_pkg::resp_item_t            resp_d;
	logic [lfsa_pkg::HINT_W-1:0]     hint_d;
	logic [lfsa_pkg::WSEL_W-1:0]     next_word;
	lfsa_pkg::zero_pos_t             zpos;
	logic [lfsa_pkg::WORD_W-1:0]     new_word;
	logic [lfsa_pkg::BIT_W-1:0]      slot_bit;
	logic [lfsa_pkg::BIT_W-1:0]      hint_bit;

	lfsa_bitmap u_bitmap (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (bmp_req),
		.rd_data (rd_data)
	);

	assign in_ready  = (state_q == S_IDLE);
	assign slot_bit  = slot_q[lfsa_pkg::BIT_W-1:0];
	assign hint_bit  = hint_q[lfsa_pkg::BIT_W-1:0];
	assign next_word = word_q + lfsa_pkg::WSEL_W'(1);

	always_comb begin
		bmp_req  = '0;
		done     = 1'b0;
		resp_d   = '0;
		hint_d   = hint_q;
		zpos     = '0;
		new_word = rd_data;

		unique case (state_q)
			S_IDLE: begin
				// fetch the word the request touches
				bmp_req.rd_en = in_valid;
				if (in_data.req_type == lfsa_pkg::REQ_RELEASE) begin
					bmp_req.rd_addr = in_data.slot_number[lfsa_pkg::SLOT_W-1:lfsa_pkg::BIT_W];
				end else begin
					bmp_req.rd_addr = hint_q[lfsa_pkg::SLOT_W-1:lfsa_pkg::BIT_W];
				end
			end
			S_MODIFY: begin
				if (req_q == lfsa_pkg::REQ_RESERVE) begin
					if (hint_q >= lfsa_pkg::HINT_FULL) begin
						done          = 1'b1;
						resp_d.status = lfsa_pkg::ST_FULL;
					end else begin
						// grant the hinted slot, then look above it in the same word
						new_word            = rd_data | lfsa_pkg::bit_sel(hint_bit);
						bmp_req.wr_en       = 1'b1;
						bmp_req.wr_addr     = word_q;
						bmp_req.wr_data     = new_word;
						resp_d.status       = lfsa_pkg::ST_OK;
						resp_d.granted_slot = hint_q[lfsa_pkg::SLOT_W-1:0];
						zpos = lfsa_pkg::first_zero(new_word | lfsa_pkg::low_mask(hint_bit));
						if (zpos.found) begin
							done   = 1'b1;
							hint_d = {1'b0, word_q, zpos.idx};
						end else if (word_q == lfsa_pkg::LAST_WORD) begin
							done   = 1'b1;
							hint_d = lfsa_pkg::HINT_FULL;
						end else begin
							bmp_req.rd_en   = 1'b1;
							bmp_req.rd_addr = next_word;
						end
					end
				end else begin
					done = 1'b1;
					if (slot_q == '0 || {1'b0, slot_q} >= lfsa_pkg::HINT_FULL
							|| !rd_data[slot_bit]) begin
						resp_d.status = lfsa_pkg::ST_BAD_RELEASE;
					end else begin
						new_word        = rd_data & ~lfsa_pkg::bit_sel(slot_bit);
						bmp_req.wr_en   = 1'b1;
						bmp_req.wr_addr = word_q;
						bmp_req.wr_data = new_word;
						resp_d.status   = lfsa_pkg::ST_OK;
						if (hint_q > {1'b0, slot_q}) begin
							hint_d = {1'b0, slot_q};
						end
					end
				end
			end
			S_SCAN: begin
				// rd_data holds word word_q; resp_q already has the grant
				resp_d = resp_q;
				zpos   = lfsa_pkg::first_zero(rd_data);
				if (zpos.found) begin
					done   = 1'b1;
					hint_d = {1'b0, word_q, zpos.idx};
				end else if (word_q == lfsa_pkg::LAST_WORD) begin
					done   = 1'b1;
					hint_d = lfsa_pkg::HINT_FULL;
				end else begin
					bmp_req.rd_en   = 1'b1;
					bmp_req.rd_addr = next_word;
				end
			end
			S_OUT: begin
			end
			default: begin
			end
		endcase
		resp_d.next_free_hint = hint_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			hint_q    <= lfsa_pkg::HINT_RESET;
			req_q     <= lfsa_pkg::REQ_RESERVE;
			slot_q    <= '0;
			word_q    <= '0;
			resp_q    <= '0;
			out_data  <= '0;
			out_valid <= 1'b0;
		end else begin
			// S_OUT loads a result or holds the one still waiting
			if (state_q == S_OUT) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						req_q  <= in_data.req_type;
						slot_q <= in_data.slot_number;
						if (in_data.req_type == lfsa_pkg::REQ_RELEASE) begin
							word_q <= in_data.slot_number[lfsa_pkg::SLOT_W-1:lfsa_pkg::BIT_W];
						end else begin
							word_q <= hint_q[lfsa_pkg::SLOT_W-1:lfsa_pkg::BIT_W];
						end
						state_q <= S_MODIFY;
					end
				end
				S_MODIFY, S_SCAN: begin
					resp_q <= resp_d;
					hint_q <= hint_d;
					if (done) begin
						state_q <= S_OUT;
					end else begin
						word_q  <= next_word;
						state_q <= S_SCAN;
					end
				end
				S_OUT: begin
					if (!out_valid || out_ready) begin
						out_data <= resp_q;
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

@@ rtl/core/lfsa_checker.sv @@
module lfsa_checker (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   out_valid,
	input  logic                   out_ready,
	input  lfsa_pkg::resp_item_t   out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	a_full_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == lfsa_pkg::ST_FULL |->
		out_data.granted_slot == '0 && out_data.next_free_hint == lfsa_pkg::HINT_FULL)
		else $error("full result malformed");

	a_hint_past_grant: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == lfsa_pkg::ST_OK && out_data.granted_slot != '0 |->
		out_data.next_free_hint > {1'b0, out_data.granted_slot})
		else $error("hint not past granted slot");

	a_hint_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.next_free_hint != '0)
		else $error("hint points at reserved slot");

	a_bad_no_grant: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == lfsa_pkg::ST_BAD_RELEASE |->
		out_data.granted_slot == '0)
		else $error("grant on bad release");

endmodule

bind lowest_free_slot_allocator lfsa_checker u_lfsa_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

@@ dv/tb.sv @@
`timescale 1ns / 100ps

module tb;

	localparam int CLK_HALF    = 6;
	localparam int RESET_CYC   = 12;
	localparam int LIMIT_CYC   = 500000;
	localparam int DRAIN_CYC   = 60;     // margin for the longest reserve scan
	localparam int HOLD_CYC    = 250;    // long receiver hold-off
	localparam int MIX_ITEMS   = 150;
	localparam int DRAIN_ITEMS = 150;

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	lfsa_pkg::req_item_t  in_data  = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	lfsa_pkg::resp_item_t out_data;

	// request stream and predicted results
	lfsa_pkg::req_item_t  pending_reqs[$];
	lfsa_pkg::resp_item_t expected_resps[$];

	// predictor state: occupied bit per slot, lowest free hint
	bit                          slot_busy[lfsa_pkg::SLOT_COUNT];
	logic [lfsa_pkg::HINT_W-1:0] lowest_free = lfsa_pkg::HINT_RESET;

	// generator shadow, only used to shape the stimulus
	bit gen_busy[lfsa_pkg::SLOT_COUNT];
	int gen_busy_cnt = 0;

	// handshake bookkeeping
	logic in_taken  = 1'b0;
	logic out_taken = 1'b0;
	int   in_gap    = 0;
	int   out_wait  = 0;
	int   sent_cnt  = 0;
	int   results_seen = 0;
	int   errors    = 0;
	int   cycle_cnt = 0;

	lowest_free_slot_allocator i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always #CLK_HALF clk = ~clk;

	// Predict one request and update the predictor state.
	function automatic lfsa_pkg::resp_item_t alloc_predict(input lfsa_pkg::req_item_t r);
		lfsa_pkg::resp_item_t p;
		p = '0;
		p.status = lfsa_pkg::ST_OK;
		if (r.req_type == lfsa_pkg::REQ_RESERVE) begin
			if (lowest_free >= lfsa_pkg::HINT_FULL) begin
				p.status = lfsa_pkg::ST_FULL;
			end else begin
				p.granted_slot = lowest_free[lfsa_pkg::SLOT_W-1:0];
				slot_busy[lowest_free] = 1'b1;
				lowest_free = lowest_free + 1'b1;
				// walk the hint up to the next free slot, or to full
				while (lowest_free < lfsa_pkg::HINT_FULL && slot_busy[lowest_free])
					lowest_free = lowest_free + 1'b1;
			end
		end else begin
			// slot 0 is reserved; a free slot cannot be released either.
			// the 10-bit field cannot name a slot beyond the table.
			if (r.slot_number == '0 || !slot_busy[r.slot_number]) begin
				p.status = lfsa_pkg::ST_BAD_RELEASE;
			end else begin
				slot_busy[r.slot_number] = 1'b0;
				if (lowest_free > {1'b0, r.slot_number})
					lowest_free = {1'b0, r.slot_number};
			end
		end
		p.next_free_hint = lowest_free;
		return p;
	endfunction

	// Append a request to the stream and track occupancy for shaping.
	task automatic queue_req(input logic rt, input logic [lfsa_pkg::SLOT_W-1:0] sn);
		lfsa_pkg::req_item_t r;
		int s;
		r.req_type    = rt;
		r.slot_number = sn;
		pending_reqs.push_back(r);
		if (rt == lfsa_pkg::REQ_RESERVE) begin
			for (s = 1; s < lfsa_pkg::SLOT_COUNT && gen_busy[s]; s++)
				;
			if (s < lfsa_pkg::SLOT_COUNT) begin
				gen_busy[s] = 1'b1;
				gen_busy_cnt++;
			end
		end else if (sn != '0 && gen_busy[sn]) begin
			gen_busy[sn] = 1'b0;
			gen_busy_cnt--;
		end
	endtask

	// Uniform pick among currently occupied slots (caller ensures one exists).
	function automatic logic [lfsa_pkg::SLOT_W-1:0] pick_busy_slot();
		int k;
		k = $urandom_range(0, gen_busy_cnt - 1);
		for (int s = 1; s < lfsa_pkg::SLOT_COUNT; s++) begin
			if (gen_busy[s]) begin
				if (k == 0)
					return lfsa_pkg::SLOT_W'(s);
				k--;
			end
		end
		return '0;
	endfunction

	// Release that is mostly well-formed, sometimes noise (random slot or slot 0).
	function automatic logic [lfsa_pkg::SLOT_W-1:0] release_target(input int noise_pct);
		int p;
		p = $urandom_range(0, 99);
		if (gen_busy_cnt != 0 && p >= noise_pct)
			return pick_busy_slot();
		if (p < 3)
			return '0;
		return lfsa_pkg::SLOT_W'($urandom_range(0, lfsa_pkg::SLOT_COUNT - 1));
	endfunction

	// Driver: new request at the falling edge once the last one was taken.
	// Each item carries a random idle gap (in_gap) after it is accepted;
	// every fifth stretch of 64 items runs back to back.
	always @(negedge clk) begin
		if (arst_n && !(in_valid && !in_taken)) begin
			if (in_gap != 0) begin
				in_valid <= 1'b0;
				in_gap   <= in_gap - 1;
			end else if (pending_reqs.size() != 0) begin
				in_data  <= pending_reqs.pop_front();
				in_valid <= 1'b1;
				in_gap   <= (((sent_cnt >> 6) % 5) == 4) ? 0 : $urandom_range(0, 6);
				sent_cnt <= sent_cnt + 1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: after each result, ready may drop while out_wait runs down.
	// Twice in the run it holds off for a long stretch so the block backs up
	// and stalls its input while the driver keeps offering.
	always @(negedge clk) begin
		int w;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (out_taken) begin
			w = (((results_seen >> 6) % 5) == 2) ? 0 : $urandom_range(0, 6);
			if (results_seen == 300 || results_seen == 1000)
				w = HOLD_CYC;
			out_wait  <= w;
			out_ready <= (w == 0);
		end else if (out_wait != 0) begin
			out_wait  <= out_wait - 1;
			out_ready <= (out_wait == 1);
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Monitor: predict on input accept, check on output accept.
	// The push of a new prediction and the pop of an older one may fall on
	// the same edge; the pop always hits an item accepted cycles earlier.
	always @(posedge clk) begin
		lfsa_pkg::resp_item_t want;
		in_taken  <= arst_n && in_valid && in_ready;
		out_taken <= arst_n && out_valid && out_ready;
		if (arst_n) begin
			if (in_valid && in_ready)
				expected_resps.push_back(alloc_predict(in_data));
			if (out_valid && out_ready) begin
				results_seen <= results_seen + 1;
				if (expected_resps.size() == 0) begin
					$error("result with no request pending: %p", out_data);
					errors++;
				end else begin
					want = expected_resps.pop_front();
					if (out_data.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, out_data.status);
						errors++;
					end
					if (out_data.granted_slot !== want.granted_slot) begin
						$error("granted_slot: expected %0d, got %0d",
							want.granted_slot, out_data.granted_slot);
						errors++;
					end
					if (out_data.next_free_hint !== want.next_free_hint) begin
						$error("next_free_hint: expected %0d, got %0d",
							want.next_free_hint, out_data.next_free_hint);
						errors++;
					end
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == LIMIT_CYC) begin
			$display("tb: errors");
			$finish;
		end
	end

	initial begin
		int p;

		// directed opener; hint starts at 1
		queue_req(lfsa_pkg::REQ_RESERVE, '0);           // grant 1
		queue_req(lfsa_pkg::REQ_RESERVE, '1);           // grant 2, slot field ignored
		queue_req(lfsa_pkg::REQ_RESERVE, 10'h155);      // grant 3
		queue_req(lfsa_pkg::REQ_RELEASE, 10'd2);        // ok, hint drops to 2
		queue_req(lfsa_pkg::REQ_RELEASE, 10'd2);        // already free
		queue_req(lfsa_pkg::REQ_RELEASE, '0);           // reserved slot zero
		queue_req(lfsa_pkg::REQ_RELEASE, '1);           // top slot, free
		queue_req(lfsa_pkg::REQ_RELEASE, 10'd512);      // free
		queue_req(lfsa_pkg::REQ_RESERVE, 10'h2aa);      // grant 2, hint jumps to 4
		queue_req(lfsa_pkg::REQ_RELEASE, 10'd1);        // hint drops to 1
		queue_req(lfsa_pkg::REQ_RELEASE, 10'd3);        // above hint, hint stays 1
		queue_req(lfsa_pkg::REQ_RESERVE, '0);           // grant 1, hint 3
		queue_req(lfsa_pkg::REQ_RELEASE, 10'h155);      // free
		queue_req(lfsa_pkg::REQ_RELEASE, 10'h2aa);      // free

		// mixed traffic at low occupancy
		repeat (MIX_ITEMS) begin
			p = $urandom_range(0, 99);
			if (p < 55)
				queue_req(lfsa_pkg::REQ_RESERVE, lfsa_pkg::SLOT_W'($urandom));
			else
				queue_req(lfsa_pkg::REQ_RELEASE, release_target(20));
		end

		// fill the table, punching a few holes on the way
		while (gen_busy_cnt < lfsa_pkg::SLOT_COUNT - 1) begin
			p = $urandom_range(0, 99);
			if (p < 92 || gen_busy_cnt == 0)
				queue_req(lfsa_pkg::REQ_RESERVE, lfsa_pkg::SLOT_W'($urandom));
			else
				queue_req(lfsa_pkg::REQ_RELEASE, release_target(10));
		end

		// full table: refused reserves, top slot recycled, holes refilled
		repeat (3) queue_req(lfsa_pkg::REQ_RESERVE, lfsa_pkg::SLOT_W'($urandom));
		queue_req(lfsa_pkg::REQ_RELEASE, '1);
		queue_req(lfsa_pkg::REQ_RESERVE, '0);           // grant 1023
		queue_req(lfsa_pkg::REQ_RESERVE, '1);           // full again
		queue_req(lfsa_pkg::REQ_RELEASE, '0);
		queue_req(lfsa_pkg::REQ_RELEASE, 10'd512);
		queue_req(lfsa_pkg::REQ_RELEASE, 10'd1);
		queue_req(lfsa_pkg::REQ_RESERVE, '0);           // grant 1
		queue_req(lfsa_pkg::REQ_RESERVE, '0);           // grant 512
		queue_req(lfsa_pkg::REQ_RESERVE, '0);           // full

		// drain with scattered releases so the hint moves around
		repeat (DRAIN_ITEMS) begin
			p = $urandom_range(0, 99);
			if (p < 25)
				queue_req(lfsa_pkg::REQ_RESERVE, lfsa_pkg::SLOT_W'($urandom));
			else
				queue_req(lfsa_pkg::REQ_RELEASE, release_target(10));
		end

		repeat (RESET_CYC) @(negedge clk);
		arst_n <= 1'b1;

		while (pending_reqs.size() != 0 || in_valid || expected_resps.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);

		if (errors == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/lfsa_pkg.sv
rtl/core/lfsa_bitmap.sv
rtl/core/lowest_free_slot_allocator.sv
rtl/core/lfsa_checker.sv
dv/tb.sv
